// ----- hdl/strip_deduplicator_macros.svh -----
// Assertion macros used by the checker file of the strip deduplicator.
`ifndef STRIP_DEDUPLICATOR_MACROS_SVH
`define STRIP_DEDUPLICATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define SDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define SDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sdd_pkg.sv -----
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared widths, constants and the control type of the strip deduplicator.
// ----------------------------------------------------------------------------
`default_nettype none

package sdd_pkg;

	localparam int UNIT_W  = 8;
	localparam int LABEL_W = 8;
	localparam int COUNT_W = 9;
	localparam int LEN_W   = 6;

	localparam logic [LEN_W-1:0]   LEN_RESET = 6'd32;
	localparam logic [LABEL_W-1:0] LABEL_SAT = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_SAT = 9'h1FF;

	// Control from the search sequencer to the strip gatherer.
	typedef struct packed {
		logic take;     // a unit request is accepted this cycle
		logic restart;  // the accepted unit opens a new image
		logic clear;    // a length write resets the strip position
	} gat_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/strip_deduplicator.sv -----
// ----------------------------------------------------------------------------
// strip_deduplicator
// Gathers units into strips and looks each strip up in a dictionary of the
// distinct strips seen so far, reporting its label in order of first sight.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Direction
//  input     in_valid, in_stall, unit_value,          in
//            image_start
//  output    out_valid, out_stall, strip_label,       out
//            first_seen, table_overflow, distinct_count
//  config    cfg_wr_en, cfg_wr_data                   in
//
// A unit that does not complete a strip does not stall the input.
// A unit that completes a strip stalls the input while the stored strips
// are scanned; the dictionary memory's single read port scans one row
// per cycle. A hit ends the scan early.
// After reset the block is ready at once: the dictionary needs no clearing.
// A waiting result does not stop gathering; only the next completed strip
// waits for the output register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_deduplicator #(
	parameter int MAX_STRIP_UNITS     = 32,
	parameter int MAX_DISTINCT_STRIPS = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [sdd_pkg::LEN_W-1:0]     cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sdd_pkg::UNIT_W-1:0]    unit_value,
	input  wire logic                          image_start,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sdd_pkg::LABEL_W-1:0]        strip_label,
	output logic                               first_seen,
	output logic                               table_overflow,
	output logic [sdd_pkg::COUNT_W-1:0]        distinct_count
);

	import sdd_pkg::*;

	localparam int IDX_W = (MAX_STRIP_UNITS > 1) ? $clog2(MAX_STRIP_UNITS) : 1;
	localparam int LBL_W = $clog2(MAX_DISTINCT_STRIPS);
	localparam int CNT_W = $clog2(MAX_DISTINCT_STRIPS + 1);
	localparam int ROW_W = MAX_STRIP_UNITS * UNIT_W;

	typedef enum logic [1:0] {
		S_GATHER,
		S_SEARCH,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   len_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   addr_q;
	logic               cmp_v_s1;
	logic [LBL_W-1:0]   cmp_idx_s1;
	logic [LABEL_W-1:0] res_label_q;
	logic               res_first_q;
	logic               res_ovf_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;
	logic [LABEL_W-1:0] out_label_q;
	logic               out_first_q;
	logic               out_ovf_q;
	logic [COUNT_W-1:0] out_count_q;

	gat_ctl_t           gat_ctl;
	logic [IDX_W-1:0]   last_idx;
	logic [ROW_W-1:0]   strip;
	logic               strip_done;
	logic [ROW_W-1:0]   rd_data;
	logic               take;
	logic               issued_all;
	logic               match;
	logic               hit;
	logic               finish_miss;
	logic               full;
	logic               rd_en;
	logic               wr_en;
	logic               out_load;
	logic               count_clr;

	function automatic logic [LABEL_W-1:0] sat_label(input logic [LBL_W-1:0] v);
		if (32'(v) > 32'(LABEL_SAT)) begin
			return LABEL_SAT;
		end
		return LABEL_W'(v);
	endfunction

	function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
		if (32'(v) > 32'(COUNT_SAT)) begin
			return COUNT_SAT;
		end
		return COUNT_W'(v);
	endfunction

	// Effective strip length, held as the index of the last unit.
	always_comb begin
		if (len_q == '0) begin
			last_idx = '0;
		end else if (32'(len_q) > MAX_STRIP_UNITS) begin
			last_idx = IDX_W'(MAX_STRIP_UNITS - 1);
		end else begin
			last_idx = IDX_W'(len_q - 1'b1);
		end
	end

	// Input handshake and gatherer control.
	assign in_stall        = (state_q != S_GATHER);
	assign take            = in_valid && !in_stall;
	assign gat_ctl.take    = take;
	assign gat_ctl.restart = image_start;
	assign gat_ctl.clear   = cfg_wr_en;

	sdd_gather #(
		.MAX_STRIP_UNITS(MAX_STRIP_UNITS)
	) u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (gat_ctl),
		.unit      (unit_value),
		.last_idx  (last_idx),
		.strip     (strip),
		.strip_done(strip_done)
	);

	// Compare the row read last cycle with the strip, unit by unit.
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_STRIP_UNITS; i++) begin
			if ((i <= int'(last_idx)) &&
			    (rd_data[i*UNIT_W +: UNIT_W] != strip[i*UNIT_W +: UNIT_W])) begin
				match = 1'b0;
			end
		end
	end

	// Scan control: one row issued per cycle until a hit or the end.
	assign issued_all  = (addr_q >= count_q);
	assign hit         = (state_q == S_SEARCH) && cmp_v_s1 && match;
	assign finish_miss = (state_q == S_SEARCH) && !cmp_v_s1 && issued_all;
	assign full        = (count_q >= CNT_W'(MAX_DISTINCT_STRIPS));
	assign rd_en       = (state_q == S_SEARCH) && !hit && !issued_all;
	assign wr_en       = finish_miss && !full;

	// Output register load and dictionary clear.
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign count_clr = cfg_wr_en || ((state_q == S_GATHER) && take && image_start);

	sdd_dict #(
		.DEPTH(MAX_DISTINCT_STRIPS),
		.ROW_W(ROW_W),
		.AW   (LBL_W)
	) u_dict (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[LBL_W-1:0]),
		.wr_data(strip),
		.rd_en  (rd_en),
		.rd_addr(addr_q[LBL_W-1:0]),
		.rd_data(rd_data)
	);

	// Sequencer, dictionary count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_GATHER;
			len_q       <= LEN_RESET;
			count_q     <= '0;
			addr_q      <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			// The count is cleared by a length write or a new image and grows on a store.
			if (count_clr) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
			unique case (state_q)
				S_GATHER: begin
					if (take && strip_done) begin
						state_q  <= S_SEARCH;
						addr_q   <= '0;
						cmp_v_s1 <= 1'b0;
					end
				end
				S_SEARCH: begin
					cmp_v_s1   <= rd_en;
					cmp_idx_s1 <= addr_q[LBL_W-1:0];
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
					end
					if (hit) begin
						res_label_q <= sat_label(cmp_idx_s1);
						res_first_q <= 1'b0;
						res_ovf_q   <= 1'b0;
						res_count_q <= sat_count(count_q);
						state_q     <= S_OUT;
					end else if (finish_miss) begin
						if (full) begin
							res_label_q <= LABEL_SAT;
							res_first_q <= 1'b0;
							res_ovf_q   <= 1'b1;
							res_count_q <= sat_count(count_q);
						end else begin
							res_label_q <= sat_label(count_q[LBL_W-1:0]);
							res_first_q <= 1'b1;
							res_ovf_q   <= 1'b0;
							res_count_q <= sat_count(CNT_W'(count_q + 1'b1));
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_label_q <= res_label_q;
						out_first_q <= res_first_q;
						out_ovf_q   <= res_ovf_q;
						out_count_q <= res_count_q;
						state_q     <= S_GATHER;
					end
				end
				default: begin
					state_q <= S_GATHER;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign strip_label    = out_label_q;
	assign first_seen     = out_first_q;
	assign table_overflow = out_ovf_q;
	assign distinct_count = out_count_q;

endmodule

`default_nettype wire

// ----- hdl/sdd_dict.sv -----
// ----------------------------------------------------------------------------
// sdd_dict
// Dictionary memory: one stored strip per row, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_dict #(
	parameter int DEPTH = 256,
	parameter int ROW_W = 256,
	parameter int AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [ROW_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [ROW_W-1:0] rd_data
);

	logic [ROW_W-1:0] mem_q [DEPTH];

	// Single write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sdd_gather.sv -----
// ----------------------------------------------------------------------------
// sdd_gather
// Collects incoming units into the strip buffer and flags the unit that
// completes a strip.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_gather #(
	parameter int MAX_STRIP_UNITS = 32,
	localparam int IDX_W = (MAX_STRIP_UNITS > 1) ? $clog2(MAX_STRIP_UNITS) : 1
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sdd_pkg::gat_ctl_t                     ctl,
	input  wire logic [sdd_pkg::UNIT_W-1:0]            unit,
	input  wire logic [IDX_W-1:0]                      last_idx,
	output logic [MAX_STRIP_UNITS*sdd_pkg::UNIT_W-1:0] strip,
	output logic                                       strip_done
);

	import sdd_pkg::*;

	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  pos_eff;
	logic [UNIT_W-1:0] buf_q [MAX_STRIP_UNITS];

	// A new image restarts the strip before this unit is placed.
	assign pos_eff    = ctl.restart ? '0 : pos_q;
	assign strip_done = ctl.take && (pos_eff == last_idx);

	// Position within the current strip.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.clear) begin
			pos_q <= '0;
		end else if (ctl.take) begin
			pos_q <= strip_done ? '0 : pos_eff + 1'b1;
		end
	end

	// Strip buffer; only positions written in this strip are ever compared.
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			buf_q[pos_eff] <= unit;
		end
	end

	for (genvar i = 0; i < MAX_STRIP_UNITS; i++) begin : g_strip
		assign strip[i*UNIT_W +: UNIT_W] = buf_q[i];
	end

endmodule

`default_nettype wire

// ----- hdl/sdd_checker.sv -----
// ----------------------------------------------------------------------------
// sdd_checker
// Port-level checks on the result channel of the strip deduplicator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "strip_deduplicator_macros.svh"

module sdd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [sdd_pkg::LABEL_W-1:0]   strip_label,
	input wire logic                          first_seen,
	input wire logic                          table_overflow,
	input wire logic [sdd_pkg::COUNT_W-1:0]   distinct_count
);

	import sdd_pkg::*;

	// A stalled result stays offered.
	`SDD_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")

	// A strip is never both newly stored and refused.
	`SDD_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !(first_seen && table_overflow), "new and overflow")

	// A refused strip carries the saturated label.
	`SDD_ASSERT_IMP(a_ovf, clk, arst_n, out_valid && table_overflow, strip_label == LABEL_SAT, "overflow label")

	// A newly stored strip leaves at least one entry in the dictionary.
	`SDD_ASSERT_IMP(a_cnt, clk, arst_n, out_valid && first_seen, distinct_count != '0, "empty after store")

endmodule

bind strip_deduplicator sdd_checker u_sdd_checker (.*);

`default_nettype wire

// ----- verif/tb_strip_deduplicator.sv -----
// ----------------------------------------------------------------------------
// tb_strip_deduplicator
// Self-checking testbench for the strip deduplicator. A short directed table
// exercises labels, repeats, image restarts and odd length settings. Random
// phases then send mostly repeated strips from a small pool, plus noise units,
// under three idling patterns, and fill the dictionary past its capacity.
// Every result is checked against the directed table or a behavioural predictor in this file.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_strip_deduplicator;

	timeunit 1ns;
	timeprecision 1ps;

	import sdd_pkg::*;

	localparam int STRIP_MAX  = 32;
	localparam int DICT_MAX   = 256;
	localparam int SETTLE_CYC = 300;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               first;
		logic               ovf;
		logic [COUNT_W-1:0] count;
	} strip_result_t;

	typedef struct {
		bit              wr;
		bit [LEN_W-1:0]  wr_len;
		bit [UNIT_W-1:0] unit;
		bit              start;
		bit              typed;
		bit              has;
		strip_result_t   res;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [LEN_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [UNIT_W-1:0]   unit_value = '0;
	logic                image_start = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LABEL_W-1:0]  strip_label;
	logic                first_seen;
	logic                table_overflow;
	logic [COUNT_W-1:0]  distinct_count;

	// Predictor state.
	bit [UNIT_W-1:0] gather_units [STRIP_MAX];
	bit [UNIT_W-1:0] dict_units [DICT_MAX][STRIP_MAX];
	int unsigned     gather_pos;
	int unsigned     dict_count;
	bit [LEN_W-1:0]  len_reg = LEN_RESET;

	strip_result_t expected_strips [$];
	int  errors = 0;
	int  units_sent = 0;
	int  strips_checked = 0;
	int  cycles = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  cur_typed = 0;
	bit  cur_has = 0;
	strip_result_t cur_res;

	dir_row_t dir_rows [$];
	bit [UNIT_W-1:0] pool [16][STRIP_MAX];

	strip_deduplicator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.unit_value(unit_value), .image_start(image_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.strip_label(strip_label), .first_seen(first_seen),
		.table_overflow(table_overflow), .distinct_count(distinct_count)
	);

	always #5 clk = ~clk;

	function automatic int unsigned eff_len(bit [LEN_W-1:0] l);
		if (l == 0) return 1;
		if (l > STRIP_MAX) return STRIP_MAX;
		return l;
	endfunction

	// Gather one unit and, at a strip end, look the strip up.
	function automatic bit dedup_predict(bit [UNIT_W-1:0] u, bit s,
			output strip_result_t r);
		int unsigned len;
		bit same;
		len = eff_len(len_reg);
		r = '0;
		if (s) begin
			gather_pos = 0;
			dict_count = 0;
		end
		if (gather_pos >= len) gather_pos = 0;
		gather_units[gather_pos] = u;
		gather_pos++;
		if (gather_pos < len) return 0;
		gather_pos = 0;
		for (int k = 0; k < dict_count; k++) begin
			same = 1;
			for (int i = 0; i < len; i++)
				if (dict_units[k][i] != gather_units[i]) same = 0;
			if (same) begin
				r.label = k;
				r.count = dict_count;
				return 1;
			end
		end
		if (dict_count >= DICT_MAX) begin
			r.label = LABEL_SAT;
			r.ovf = 1;
			r.count = dict_count;
			return 1;
		end
		for (int i = 0; i < len; i++) dict_units[dict_count][i] = gather_units[i];
		r.label = dict_count;
		dict_count++;
		r.first = 1;
		r.count = dict_count;
		return 1;
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $realtime,
				expected_strips.size());
			$display("strip_deduplicator regression: fail");
			$finish;
		end
	end

	// Predict on accepted requests, check accepted results.
	always @(posedge clk) begin
		strip_result_t r, got, exp;
		bit has;
		if (arst_n && in_valid && !in_stall) begin
			has = dedup_predict(unit_value, image_start, r);
			units_sent++;
			if (cur_typed) begin
				if (cur_has) expected_strips.push_back(cur_res);
			end else if (has) begin
				expected_strips.push_back(r);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{strip_label, first_seen, table_overflow, distinct_count};
			strips_checked++;
			if (expected_strips.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p",
					$realtime, got);
			end else begin
				exp = expected_strips.pop_front();
				if (got.label !== exp.label || got.first !== exp.first ||
						got.ovf !== exp.ovf || got.count !== exp.count) begin
					errors++;
					$display("%0t: mismatch, expected %p, actual %p",
						$realtime, exp, got);
				end
			end
		end
	end

	// Receiver stalls at random.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic wait_drained();
		while (expected_strips.size() != 0) @(negedge clk);
	endtask

	// Length write while the block is idle; it also clears the dictionary.
	task automatic write_length(bit [LEN_W-1:0] v);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= $urandom;
		len_reg = v;
		gather_pos = 0;
		dict_count = 0;
	endtask

	// Offer one unit request and hold it until it is taken.
	task automatic send_unit(bit [UNIT_W-1:0] u, bit s);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		unit_value <= u;
		image_start <= s;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Pool-driven random strips with noise units and occasional restarts.
	task automatic run_phase(bit [LEN_W-1:0] l, int n_units, int pool_n, bit hold);
		int unsigned len;
		int sent;
		int p;
		write_length(l);
		len = eff_len(l);
		for (int j = 0; j < pool_n; j++)
			for (int i = 0; i < STRIP_MAX; i++) pool[j][i] = $urandom;
		sent = 0;
		while (sent < n_units) begin
			if ($urandom_range(99) < 8) begin
				send_unit($urandom, $urandom_range(99) < 20);
				sent++;
			end else begin
				p = $urandom_range(pool_n - 1);
				for (int i = 0; i < len; i++) begin
					send_unit(pool[p][i], i == 0 && $urandom_range(99) < 4);
					sent++;
				end
			end
			if (hold && sent >= n_units / 2 && sent < n_units / 2 + len) begin
				in_valid <= 1'b0;
				wait_drained();
				@(negedge clk);
			end
		end
	endtask

	// Fill the dictionary past its capacity with two-unit strips.
	task automatic run_overflow();
		write_length(2);
		for (int k = 0; k < DICT_MAX + 2; k++) begin
			send_unit(k >> 8, 0);
			send_unit(k[7:0], 0);
		end
		send_unit($urandom_range(1), 0);
		send_unit($urandom, 0);
	endtask

	function automatic dir_row_t row(bit [UNIT_W-1:0] u, bit s, bit typed, bit has,
			int lbl, bit f, bit o, int c);
		dir_row_t d;
		d.wr = 0;
		d.wr_len = 0;
		d.unit = u;
		d.start = s;
		d.typed = typed;
		d.has = has;
		d.res = '{lbl, f, o, c};
		return d;
	endfunction

	function automatic dir_row_t wr_row(bit [LEN_W-1:0] l);
		dir_row_t d;
		d = row(0, 0, 0, 0, 0, 0, 0, 0);
		d.wr = 1;
		d.wr_len = l;
		return d;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: single-unit strips give labels that are easy to read.
		dir_rows.push_back(wr_row(1));
		dir_rows.push_back(row(8'h00, 1, 1, 1, 0, 1, 0, 1));
		dir_rows.push_back(row(8'hFF, 0, 1, 1, 1, 1, 0, 2));
		dir_rows.push_back(row(8'h00, 0, 1, 1, 0, 0, 0, 2));
		dir_rows.push_back(row(8'hFF, 0, 1, 1, 1, 0, 0, 2));
		dir_rows.push_back(row(8'hAA, 0, 1, 1, 2, 1, 0, 3));
		dir_rows.push_back(row(8'h55, 1, 1, 1, 0, 1, 0, 1));
		dir_rows.push_back(row(8'hAA, 0, 1, 1, 1, 1, 0, 2));
		// Zero length behaves as one; the write also clears the dictionary.
		dir_rows.push_back(wr_row(0));
		dir_rows.push_back(row(8'hAA, 0, 1, 1, 0, 1, 0, 1));
		dir_rows.push_back(row(8'h07, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(8'h07, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(8'hC8, 1, 0, 0, 0, 0, 0, 0));
		// Oversized length behaves as the maximum strip size.
		dir_rows.push_back(wr_row(6'd63));
		for (int i = 0; i < 12; i++)
			dir_rows.push_back(row(i * 21, i == 0, 0, 0, 0, 0, 0, 0));
		foreach (dir_rows[n]) begin
			if (dir_rows[n].wr) begin
				write_length(dir_rows[n].wr_len);
			end else begin
				cur_typed = dir_rows[n].typed;
				cur_has = dir_rows[n].has;
				cur_res = dir_rows[n].res;
				send_unit(dir_rows[n].unit, dir_rows[n].start);
			end
		end
		cur_typed = 0;

		// Sender idles more lightly than the receiver.
		send_idle_pct = 36;
		recv_idle_pct = 73;
		run_phase(6'd3, 24, 4, 1);
		run_phase(6'd63, 20, 3, 0);
		// Then the other way round.
		send_idle_pct = 73;
		recv_idle_pct = 36;
		run_phase($urandom_range(1, 8), 16, 5, 0);
		run_phase(6'd1, 12, 6, 0);
		// No idling at all.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(6'd0, 10, 8, 1);
		run_overflow();

		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		if (expected_strips.size() != 0) errors++;
		$display("Sent %0d units and checked %0d strip results over several lengths,",
			units_sent, strips_checked);
		$display("idling patterns, image restarts and a dictionary overflow.");
		if (errors == 0)
			$display("strip_deduplicator regression: pass");
		else
			$display("strip_deduplicator regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/sdd_pkg.sv
hdl/sdd_dict.sv
hdl/sdd_gather.sv
hdl/strip_deduplicator.sv
hdl/sdd_checker.sv
verif/tb_strip_deduplicator.sv
